FILE: sv/nearest_vertex_to_ray_pick_unit_assert.svh
// Assertion macros for the ray pick unit.
`ifndef NEAREST_VERTEX_TO_RAY_PICK_UNIT_ASSERT_SVH
`define NEAREST_VERTEX_TO_RAY_PICK_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: sv/nvp_pkg.sv
// Shared types and constants of the ray pick unit.
package nvp_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int DIR_W        = 18;
  localparam int RAD_W        = 31;
  localparam int STEPS        = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd6;

  // request kinds
  localparam logic [1:0] KIND_PICK      = 2'd0;
  localparam logic [1:0] KIND_PICK_LAST = 2'd1;
  localparam logic [1:0] KIND_PROJECT   = 2'd2;

  typedef struct packed {
    logic signed [31:0]      org_x;
    logic signed [31:0]      org_y;
    logic signed [31:0]      org_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [RAD_W-1:0]        radius;
  } ray_cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   index;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
  } res_t;

endpackage

FILE: sv/nearest_vertex_to_ray_pick_unit.sv
// Nearest vertex to ray picker, Q16.16: a request enters a two-entry queue and is then
// carried through an eight-step datapath (difference, dot product, rounding, foot point,
// distance, squares, saturating sum, search update) that handles one request at a time,
// taking a new request from the queue only once the last one has left the datapath and
// the two-entry result queue has room. Pick requests without the last mark give no
// result; the last one returns the nearest vertex inside the pick radius and clears the
// search; a project request returns its foot point.
module nearest_vertex_to_ray_pick_unit import nvp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic                 in_op,
  input  logic signed [31:0]   in_vertex_x,
  input  logic signed [31:0]   in_vertex_y,
  input  logic signed [31:0]   in_vertex_z,
  input  logic                 in_last_vertex,
  output logic                 empty,
  input  logic                 pop,
  output logic                 out_found,
  output logic [IDX_W-1:0]     out_picked_index,
  output logic signed [31:0]   out_foot_x,
  output logic signed [31:0]   out_foot_y,
  output logic signed [31:0]   out_foot_z
);

`include "nearest_vertex_to_ray_pick_unit_assert.svh"

  ray_cfg_t cfg_r;
  logic     req_valid;
  req_t     req;
  logic     req_pop;
  logic     res_full;
  logic     res_wr;
  res_t     res_in;
  res_t     res_out;
  logic     res_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.org_x  <= '0;
      cfg_r.org_y  <= '0;
      cfg_r.org_z  <= '0;
      cfg_r.dir_x  <= '0;
      cfg_r.dir_y  <= '0;
      cfg_r.dir_z  <= -18'sd65536;
      cfg_r.radius <= 31'd19661;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ORIGIN_X: cfg_r.org_x  <= cfg_data;
        CFG_ORIGIN_Y: cfg_r.org_y  <= cfg_data;
        CFG_ORIGIN_Z: cfg_r.org_z  <= cfg_data;
        CFG_DIR_X:    cfg_r.dir_x  <= cfg_data[DIR_W-1:0];
        CFG_DIR_Y:    cfg_r.dir_y  <= cfg_data[DIR_W-1:0];
        CFG_DIR_Z:    cfg_r.dir_z  <= cfg_data[DIR_W-1:0];
        CFG_RADIUS:   cfg_r.radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  nvp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .op          (in_op),
    .vertex_x    (in_vertex_x),
    .vertex_y    (in_vertex_y),
    .vertex_z    (in_vertex_z),
    .last_vertex (in_last_vertex),
    .req_valid   (req_valid),
    .req         (req),
    .req_pop     (req_pop)
  );

  nvp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .res_full  (res_full),
    .res_wr    (res_wr),
    .res       (res_in)
  );

  nvp_res_queue u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (res_wr),
    .wdata (res_in),
    .full  (res_full),
    .empty (empty),
    .pop   (pop),
    .rdata (res_out)
  );

  assign out_found        = res_out.found;
  assign out_picked_index = res_out.index;
  assign out_foot_x       = res_out.fx;
  assign out_foot_y       = res_out.fy;
  assign out_foot_z       = res_out.fz;

  assign res_zero = (out_picked_index == '0) && (out_foot_x == '0) && (out_foot_y == '0) &&
                    (out_foot_z == '0);

  `ASSERT_IMPLIES(a_pop_needs_req, req_pop, req_valid)
  `ASSERT_IMPLIES(a_result_has_room, res_wr, !res_full)
  `ASSERT_NEXT(a_result_shows, res_wr, !empty)
  `ASSERT_IMPLIES(a_miss_is_zero, !empty && !out_found, res_zero)

endmodule

FILE: sv/nvp_front.sv
// Front end: classifies incoming requests and queues them for the back end.
module nvp_front import nvp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               op,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  input  logic signed [31:0] vertex_z,
  input  logic               last_vertex,
  output logic               req_valid,
  output req_t               req,
  input  logic               req_pop
);

  req_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en, rd_en;
  req_t       incoming;

  always_comb begin
    incoming.vx = vertex_x;
    incoming.vy = vertex_y;
    incoming.vz = vertex_z;
    if (op) begin
      incoming.kind = KIND_PROJECT;
    end else if (last_vertex) begin
      incoming.kind = KIND_PICK_LAST;
    end else begin
      incoming.kind = KIND_PICK;
    end
  end

  assign full      = (cnt_r == 2'd2);
  assign req_valid = (cnt_r != 2'd0);
  assign req       = mem_r[rd_ptr_r];
  assign wr_en     = push && !full;
  assign rd_en     = req_pop && req_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr_en;
    rd_ptr_nxt = rd_ptr_r ^ rd_en;
    cnt_nxt    = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= incoming;
    end
  end

endmodule

FILE: sv/nvp_back.sv
// Back end: foot point and distance datapath, running nearest search.
module nvp_back import nvp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ray_cfg_t cfg,
  input  logic     req_valid,
  input  req_t     req,
  output logic     req_pop,
  input  logic     res_full,
  output logic     res_wr,
  output res_t     res
);

  logic [STEPS-1:0] stg_r, stg_nxt;
  logic             busy;

  logic [1:0]              kind_r;
  logic signed [31:0]      p_r    [3];
  logic signed [32:0]      diff_r [3];
  logic signed [50:0]      prod_r [3];
  logic [2*RAD_W-1:0]      rsq_r;
  logic signed [36:0]      t_r;
  logic signed [54:0]      tp_r   [3];
  logic signed [39:0]      foot_r [3];
  logic signed [31:0]      fsat_r [3];
  logic [31:0]             mag_r  [3];
  logic [2:0]              big_r;
  logic [63:0]             sq_r   [3];
  logic [2:0]              big2_r;
  logic [63:0]             dsq_r;

  logic signed [31:0]      org   [3];
  logic signed [DIR_W-1:0] dir   [3];
  logic signed [31:0]      pin   [3];
  logic signed [52:0]      dot;
  logic signed [54:0]      tp_rnd [3];
  logic signed [39:0]      foot   [3];
  logic signed [40:0]      dvec   [3];
  logic [40:0]             mag    [3];
  logic [65:0]             sq_sum;

  // search state
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic signed [31:0] bfoot_r [3];
  logic signed [31:0] bfoot_nxt [3];
  logic [63:0]        best_r;
  logic [63:0]        limit;
  logic               hit;
  logic               step_last;

  assign org[0] = cfg.org_x;
  assign org[1] = cfg.org_y;
  assign org[2] = cfg.org_z;
  assign dir[0] = cfg.dir_x;
  assign dir[1] = cfg.dir_y;
  assign dir[2] = cfg.dir_z;
  assign pin[0] = req.vx;
  assign pin[1] = req.vy;
  assign pin[2] = req.vz;

  assign busy    = |stg_r;
  assign req_pop = req_valid && !busy && !res_full;
  assign stg_nxt = {stg_r[STEPS-2:0], req_pop};
  assign step_last = stg_r[STEPS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
    end else begin
      stg_r <= stg_nxt;
    end
  end

  // round to Q16.16: add one half, floor
  assign dot = 53'(prod_r[0]) + 53'(prod_r[1]) + 53'(prod_r[2]) + 53'sd32768;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tp_rnd[i] = tp_r[i] + 55'sd32768;
      foot[i]   = 40'(org[i]) + 40'($signed(tp_rnd[i][54:16]));
      dvec[i]   = 41'(p_r[i]) - 41'(foot_r[i]);
      mag[i]    = dvec[i][40] ? 41'(-dvec[i]) : 41'(dvec[i]);
    end
  end

  assign sq_sum = 66'(sq_r[0]) + 66'(sq_r[1]) + 66'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (req_pop) begin
      kind_r <= req.kind;
      for (int i = 0; i < 3; i++) begin
        p_r[i]    <= pin[i];
        diff_r[i] <= 33'(pin[i]) - 33'(org[i]);
      end
    end
    if (stg_r[0]) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= diff_r[i] * dir[i];
      end
      rsq_r <= 62'(cfg.radius) * 62'(cfg.radius);
    end
    if (stg_r[1]) begin
      t_r <= dot[52:16];
    end
    if (stg_r[2]) begin
      for (int i = 0; i < 3; i++) begin
        tp_r[i] <= t_r * dir[i];
      end
    end
    if (stg_r[3]) begin
      for (int i = 0; i < 3; i++) begin
        foot_r[i] <= foot[i];
      end
    end
    if (stg_r[4]) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= mag[i][31:0];
        big_r[i] <= |mag[i][40:32];
        if (foot_r[i][39:31] == '0 || foot_r[i][39:31] == '1) begin
          fsat_r[i] <= foot_r[i][31:0];
        end else if (foot_r[i][39]) begin
          fsat_r[i] <= 32'sh8000_0000;
        end else begin
          fsat_r[i] <= 32'sh7fff_ffff;
        end
      end
    end
    if (stg_r[5]) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= mag_r[i] * mag_r[i];
      end
      big2_r <= big_r;
    end
    if (stg_r[6]) begin
      // saturate on a huge component or on 64-bit overflow
      if (|big2_r || |sq_sum[65:64]) begin
        dsq_r <= '1;
      end else begin
        dsq_r <= sq_sum[63:0];
      end
    end
  end

  assign limit = found_r ? best_r : 64'(rsq_r);
  assign hit   = (dsq_r < limit);

  always_comb begin
    cnt_nxt   = cnt_r;
    found_nxt = found_r;
    idx_nxt   = idx_r;
    for (int i = 0; i < 3; i++) begin
      bfoot_nxt[i] = bfoot_r[i];
    end
    if (hit) begin
      found_nxt = 1'b1;
      idx_nxt   = cnt_r;
      for (int i = 0; i < 3; i++) begin
        bfoot_nxt[i] = fsat_r[i];
      end
    end
    cnt_nxt = cnt_r + 1'b1;
  end

  always_comb begin
    res_wr = step_last && (kind_r != KIND_PICK);
    if (kind_r == KIND_PROJECT) begin
      res.found = 1'b1;
      res.index = '0;
      res.fx    = fsat_r[0];
      res.fy    = fsat_r[1];
      res.fz    = fsat_r[2];
    end else begin
      res.found = found_nxt;
      res.index = idx_nxt;
      res.fx    = bfoot_nxt[0];
      res.fy    = bfoot_nxt[1];
      res.fz    = bfoot_nxt[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
      idx_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        bfoot_r[i] <= '0;
      end
    end else if (step_last && kind_r != KIND_PROJECT) begin
      if (kind_r == KIND_PICK_LAST) begin
        // report done, clear the search
        cnt_r   <= '0;
        found_r <= 1'b0;
        idx_r   <= '0;
        for (int i = 0; i < 3; i++) begin
          bfoot_r[i] <= '0;
        end
      end else begin
        cnt_r   <= cnt_nxt;
        found_r <= found_nxt;
        idx_r   <= idx_nxt;
        for (int i = 0; i < 3; i++) begin
          bfoot_r[i] <= bfoot_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_last && kind_r != KIND_PROJECT && hit) begin
      best_r <= dsq_r;
    end
  end

endmodule

FILE: sv/nvp_res_queue.sv
// Two-entry result queue feeding the output port.
module nvp_res_queue import nvp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  res_t wdata,
  output logic full,
  output logic empty,
  input  logic pop,
  output res_t rdata
);

  res_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en, rd_en;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];
  assign wr_en = wr && !full;
  assign rd_en = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr_en;
    rd_ptr_nxt = rd_ptr_r ^ rd_en;
    cnt_nxt    = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: test/nearest_vertex_to_ray_pick_unit_tb.sv
// Self-checking testbench for the nearest vertex to ray pick unit.
`timescale 1ns / 1ps

module nearest_vertex_to_ray_pick_unit_tb import nvp_pkg::*;;

  localparam bit      OP_PICK        = 1'b0;
  localparam bit      OP_PROJECT     = 1'b1;
  localparam int      SETTLE_CYCLES  = 40;
  localparam int      CYCLE_LIMIT    = 1000000;
  localparam int      RANDOM_PHASES  = 14;
  localparam int      PHASE_ITEMS    = 135;
  localparam longint  Q_MAX          = 64'sd2147483647;
  localparam longint  Q_MIN          = -64'sd2147483648;

  typedef enum {POP_STEADY, POP_TOGGLE, POP_SPARSE, POP_LONG_STALL} pop_style_t;

  // Tracks the ray setting and the open search, and holds the results still owed.
  class pick_tracker_t;
    ray_cfg_t          ray;
    logic [IDX_W-1:0]  vertex_count;
    bit [63:0]         best_dist_sq;
    logic [IDX_W-1:0]  best_index;
    bit                best_found;
    logic [31:0]       best_foot [3];
    res_t              pending_results [$];
    int                failures;
    int                searches_hit;
    int                searches_miss;
    int                projections;

    function new();
      ray = '0;
      ray.dir_z = -DIR_W'(65536);
      ray.radius = RAD_W'(19661);
      clear_search();
    endfunction

    function bit [63:0] radius_sq();
      bit [63:0] r;
      r = 64'(ray.radius);
      return r * r;
    endfunction

    function void clear_search();
      vertex_count = '0;
      best_dist_sq = radius_sq();
      best_index = '0;
      best_found = 1'b0;
      best_foot = '{default: '0};
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_ORIGIN_X: ray.org_x = data;
        CFG_ORIGIN_Y: ray.org_y = data;
        CFG_ORIGIN_Z: ray.org_z = data;
        CFG_DIR_X:    ray.dir_x = data[DIR_W-1:0];
        CFG_DIR_Y:    ray.dir_y = data[DIR_W-1:0];
        CFG_DIR_Z:    ray.dir_z = data[DIR_W-1:0];
        CFG_RADIUS:   ray.radius = data[RAD_W-1:0];
        default: ;
      endcase
    endfunction

    // floor((v + 1/2 lsb) / 2^16)
    function longint round_fix(longint v);
      return (v + 64'sd32768) >>> 16;
    endfunction

    function logic [31:0] clip32(longint v);
      if (v > Q_MAX) return 32'h7FFF_FFFF;
      if (v < Q_MIN) return 32'h8000_0000;
      return v[31:0];
    endfunction

    // Foot point on the ray and squared distance to it, saturating at all ones.
    function void foot_of(input longint p [3], output logic [31:0] fs [3],
                          output bit [63:0] dsq);
      longint o [3];
      longint d [3];
      longint dot, t, f, diff;
      bit [63:0] mag, sq;
      o[0] = longint'(ray.org_x);
      o[1] = longint'(ray.org_y);
      o[2] = longint'(ray.org_z);
      d[0] = longint'(ray.dir_x);
      d[1] = longint'(ray.dir_y);
      d[2] = longint'(ray.dir_z);
      dot = 0;
      for (int i = 0; i < 3; i++) dot += (p[i] - o[i]) * d[i];
      t = round_fix(dot);
      dsq = '0;
      for (int i = 0; i < 3; i++) begin
        f = o[i] + round_fix(t * d[i]);
        fs[i] = clip32(f);
        diff = p[i] - f;
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        if (mag >= 64'h1_0000_0000) begin
          dsq = '1;
        end else begin
          sq = mag * mag;
          dsq = (dsq > ~sq) ? '1 : dsq + sq;
        end
      end
    endfunction

    function void note_request(bit op, logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, bit last);
      longint p [3];
      logic [31:0] fs [3];
      bit [63:0] dsq, limit;
      res_t r;
      p[0] = longint'(x);
      p[1] = longint'(y);
      p[2] = longint'(z);
      foot_of(p, fs, dsq);
      if (op == OP_PROJECT) begin
        r = '{found: 1'b1, index: '0, fx: fs[0], fy: fs[1], fz: fs[2]};
        pending_results.push_back(r);
        projections++;
        return;
      end
      // until a hit, the current radius is the bar
      limit = best_found ? best_dist_sq : radius_sq();
      if (dsq < limit) begin
        best_dist_sq = dsq;
        best_index = vertex_count;
        best_found = 1'b1;
        best_foot = fs;
      end
      vertex_count = vertex_count + 1'b1;
      if (!last) return;
      if (best_found) begin
        r = '{found: 1'b1, index: best_index, fx: best_foot[0], fy: best_foot[1],
              fz: best_foot[2]};
        searches_hit++;
      end else begin
        r = '0;
        searches_miss++;
      end
      pending_results.push_back(r);
      clear_search();
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result with none pending: found=%0d index=%0d foot=(%0d,%0d,%0d)",
                   $time, got.found, got.index, got.fx, got.fy, got.fz);
        return;
      end
      want = pending_results.pop_front();
      if (got.found !== want.found || got.index !== want.index || got.fx !== want.fx ||
          got.fy !== want.fy || got.fz !== want.fz) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: result mismatch", $time);
          $display("  expected found=%0d index=%0d foot=(%0d,%0d,%0d)",
                   want.found, want.index, want.fx, want.fy, want.fz);
          $display("  actual   found=%0d index=%0d foot=(%0d,%0d,%0d)",
                   got.found, got.index, got.fx, got.fy, got.fz);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 push = 1'b0;
  logic                 full;
  logic                 in_op = 1'b0;
  logic signed [31:0]   in_vertex_x = '0;
  logic signed [31:0]   in_vertex_y = '0;
  logic signed [31:0]   in_vertex_z = '0;
  logic                 in_last_vertex = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic                 out_found;
  logic [IDX_W-1:0]     out_picked_index;
  logic signed [31:0]   out_foot_x;
  logic signed [31:0]   out_foot_y;
  logic signed [31:0]   out_foot_z;

  pick_tracker_t tracker = new();
  int            cycle_count = 0;
  int            sent_items = 0;
  int            burst_left = 0;
  int            ray_settings = 0;
  pop_style_t    pop_style = POP_STEADY;

  nearest_vertex_to_ray_pick_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .push             (push),
    .full             (full),
    .in_op            (in_op),
    .in_vertex_x      (in_vertex_x),
    .in_vertex_y      (in_vertex_y),
    .in_vertex_z      (in_vertex_z),
    .in_last_vertex   (in_last_vertex),
    .empty            (empty),
    .pop              (pop),
    .out_found        (out_found),
    .out_picked_index (out_picked_index),
    .out_foot_x       (out_foot_x),
    .out_foot_y       (out_foot_y),
    .out_foot_z       (out_foot_z)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // sample every handshake on the pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) tracker.set_register(cfg_index, cfg_data);
      if (push && !full)
        tracker.note_request(in_op, in_vertex_x, in_vertex_y, in_vertex_z, in_last_vertex);
      if (pop && !empty)
        tracker.check_result('{found: out_found, index: out_picked_index,
                               fx: out_foot_x, fy: out_foot_y, fz: out_foot_z});
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 300 == 0) pop_style <= pop_style_t'($urandom_range(0, 3));
    case (pop_style)
      POP_STEADY:  pop <= 1'b1;
      POP_TOGGLE:  pop <= ~pop;
      POP_SPARSE:  pop <= ($urandom_range(0, 3) == 0);
      default:     pop <= (cycle_count[3:0] == 4'd0);
    endcase
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               tracker.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Present one request, hold it until taken, then maybe end the burst.
  task automatic send_vertex(bit op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             bit last);
    push <= 1'b1;
    in_op <= op;
    in_vertex_x <= x;
    in_vertex_y <= y;
    in_vertex_z <= z;
    in_last_vertex <= last;
    do @(posedge clk); while (full);
    sent_items++;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end else begin
      burst_left--;
    end
  endtask

  // Wait out every owed result, then the pipeline's tail of resultless requests.
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_ray(ray_cfg_t r);
    write_register(CFG_ORIGIN_X, r.org_x);
    write_register(CFG_ORIGIN_Y, r.org_y);
    write_register(CFG_ORIGIN_Z, r.org_z);
    write_register(CFG_DIR_X, {{(CFG_W-DIR_W){r.dir_x[DIR_W-1]}}, r.dir_x});
    write_register(CFG_DIR_Y, {{(CFG_W-DIR_W){r.dir_y[DIR_W-1]}}, r.dir_y});
    write_register(CFG_DIR_Z, {{(CFG_W-DIR_W){r.dir_z[DIR_W-1]}}, r.dir_z});
    write_register(CFG_RADIUS, {{(CFG_W-RAD_W){1'b0}}, r.radius});
    cfg_wr_en <= 1'b0;
    ray_settings++;
  endtask

  function automatic ray_cfg_t make_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                        int dx, int dy, int dz, int rad);
    ray_cfg_t r;
    r.org_x = ox;
    r.org_y = oy;
    r.org_z = oz;
    r.dir_x = DIR_W'(dx);
    r.dir_y = DIR_W'(dy);
    r.dir_z = DIR_W'(dz);
    r.radius = RAD_W'(rad);
    return r;
  endfunction

  function automatic ray_cfg_t corner_ray(int n);
    case (n)
      0: return make_ray(0, 0, 0, 65536, 0, 0, 19661 * 4);
      1: return make_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, -65536, 0,
                         32'h7FFF_FFFF);
      2: return make_ray(32'h8000_0000, 0, 32'h7FFF_FFFF, -65536, 0, 0, 0);
      3: return make_ray($urandom, $urandom, $urandom, 0, 0, 0, 1 << 18);
      4: return make_ray(0, 0, 0, 65536, 65536, 65536, 1 << 17);
      default: return make_ray(0, 0, 0, 0, 0, -65536, 19661);
    endcase
  endfunction

  function automatic ray_cfg_t random_ray();
    logic [31:0] o [3];
    int          d [3];
    int          rad;
    int          axis;
    for (int i = 0; i < 3; i++)
      o[i] = ($urandom_range(0, 3) == 0) ? $urandom
                                         : $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    d = '{default: 0};
    axis = $urandom_range(0, 2);
    case ($urandom_range(0, 2))
      0: d[axis] = $urandom_range(0, 1) ? 65536 : -65536;
      1: begin
        d[axis] = $urandom_range(0, 1) ? 46341 : -46341;
        d[(axis + 1) % 3] = $urandom_range(0, 1) ? 46341 : -46341;
      end
      default: begin
        for (int i = 0; i < 3; i++) d[i] = int'($urandom_range(0, 131072)) - 65536;
      end
    endcase
    rad = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 32'h7FFF_FFFF))
                                      : int'($urandom_range(0, 1 << 19));
    return make_ray(o[0], o[1], o[2], d[0], d[1], d[2], rad);
  endfunction

  // A point near the current ray: origin plus t * dir plus an offset on the radius scale.
  function automatic void near_point(output logic [31:0] v [3]);
    longint t, span, off, c;
    longint o [3];
    longint d [3];
    o[0] = longint'(tracker.ray.org_x);
    o[1] = longint'(tracker.ray.org_y);
    o[2] = longint'(tracker.ray.org_z);
    d[0] = longint'(tracker.ray.dir_x);
    d[1] = longint'(tracker.ray.dir_y);
    d[2] = longint'(tracker.ray.dir_z);
    t = longint'($urandom_range(0, 32'h0020_0000)) - 64'sd1048576;
    span = longint'(tracker.ray.radius) + 64;
    for (int i = 0; i < 3; i++) begin
      off = longint'({$urandom, $urandom} % 64'(2 * span + 1)) - span;
      if ($urandom_range(0, 2) == 0) off = 0;
      c = o[i] + ((t * d[i]) >>> 16) + off;
      v[i] = c[31:0];
    end
  endfunction

  // One search with random content; repeats give ties, a stray projection may cut in.
  task automatic random_search(int len);
    logic [31:0] v [3];
    logic [31:0] p [3];
    near_point(v);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 14) == 0) begin
        near_point(p);
        send_vertex(OP_PROJECT, p[0], p[1], p[2], 1'($urandom_range(0, 1)));
      end
      if (n == 0 || $urandom_range(0, 7) != 0) begin
        if ($urandom_range(0, 9) == 0) v = '{$urandom, $urandom, $urandom};
        else near_point(v);
      end
      send_vertex(OP_PICK, v[0], v[1], v[2], n == len - 1);
    end
  endtask

  task automatic directed_checks();
    // reset ray: origin zero, looking down -z, radius about 0.3
    send_vertex(OP_PROJECT, 0, 0, 0, 1'b0);
    send_vertex(OP_PROJECT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_vertex(OP_PICK, 32'h0000_1000, 0, 32'h0005_0000, 1'b0);
    send_vertex(OP_PICK, 0, 0, 32'h0003_0000, 1'b0);
    send_vertex(OP_PICK, 0, 0, 32'h0007_0000, 1'b0);
    send_vertex(OP_PROJECT, 0, 32'h0002_0000, 0, 1'b0);
    send_vertex(OP_PICK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_vertex(OP_PICK, 32'h0001_0000, 0, 0, 1'b1);
    // widen the radius while a search is open and still empty
    send_vertex(OP_PICK, 32'h0000_8000, 0, 0, 1'b0);
    drain_results();
    write_register(CFG_RADIUS, 32'h0000_C000);
    cfg_wr_en <= 1'b0;
    send_vertex(OP_PICK, 32'h0000_9000, 0, 0, 1'b0);
    send_vertex(OP_PICK, 32'h0000_8000, 0, 32'h0001_0000, 1'b1);
    // zero radius: even a point on the ray misses
    drain_results();
    write_register(CFG_RADIUS, 0);
    cfg_wr_en <= 1'b0;
    send_vertex(OP_PICK, 0, 0, 0, 1'b1);
    // long diagonal direction pushes the foot point past the Q16.16 range
    drain_results();
    apply_ray(make_ray(0, 0, 0, 65536, 65536, 0, 32'h7FFF_FFFF));
    send_vertex(OP_PROJECT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1'b0);
    send_vertex(OP_PROJECT, 32'h8000_0000, 32'h8000_0000, 0, 1'b0);
    send_vertex(OP_PICK, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_vertex(OP_PICK, 32'h0001_0000, 32'h0001_0000, 32'h0040_0000, 1'b1);
    // zero direction: foot point is the origin, here at the corners
    drain_results();
    apply_ray(make_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0,
                       32'h7FFF_FFFF));
    send_vertex(OP_PROJECT, 0, 0, 0, 1'b0);
    send_vertex(OP_PICK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_vertex(OP_PICK, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
  endtask

  initial begin
    logic [31:0] v [3];
    int          phase_end;
    int          roll;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    directed_checks();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      apply_ray(phase < 6 ? corner_ray(phase) : random_ray());
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          random_search($urandom_range(1, 14));
        end else if (roll < 85) begin
          near_point(v);
          send_vertex(OP_PROJECT, v[0], v[1], v[2], 1'($urandom_range(0, 1)));
        end else begin
          send_vertex(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                      1'($urandom_range(0, 1)));
        end
      end
    end
    // close any search left open by noise
    send_vertex(OP_PICK, 0, 0, 0, 1'b1);
    drain_results();
    $display("%0d requests under %0d ray settings, with corner rays and saturated feet",
             sent_items, ray_settings);
    $display("%0d searches hit, %0d missed, %0d projections, %0d mismatches",
             tracker.searches_hit, tracker.searches_miss, tracker.projections,
             tracker.failures);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: nearest_vertex_to_ray_pick_unit.f
+incdir+sv
sv/nvp_pkg.sv
sv/nvp_front.sv
sv/nvp_back.sv
sv/nvp_res_queue.sv
sv/nearest_vertex_to_ray_pick_unit.sv
test/nearest_vertex_to_ray_pick_unit_tb.sv
